### rtl/grf_pkg.sv
// Shared types, codes and helper functions of the glyph pixel renderer.
package grf_pkg;

  // Item kinds carried in the input tuser.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_DRAW = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
  localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
  localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [2:0] REG_LINE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_FIELD_MASK  = 3'd5;
  localparam logic [2:0] REG_FG_COLOR    = 3'd6;
  localparam logic [2:0] REG_BG_COLOR    = 3'd7;

  // Port widths.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned ADDR_W     = 21;

  // Glyph code window and cursor limit.
  localparam logic [7:0]  CODE_FIRST   = 8'd32;
  localparam logic [7:0]  CODE_LAST    = 8'd127;
  localparam logic [10:0] CURSOR_X_MAX = 11'd2047;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_font;   // write one font byte
    logic set_cursor;  // place the cursor at a cell
    logic start_draw;  // latch glyph and row base of a new character
    logic fetch_row;   // read the current glyph row
    logic emit;        // load one pixel into the output register
    logic next_row;    // step to the next row and prefetch it
    logic finish;      // last pixel of the character: advance cursor
  } grf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic col_last;
    logic row_last;
    logic out_free;
  } grf_sts_t;

  // Codes outside the printable range draw glyph 0.
  function automatic logic [6:0] glyph_of(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - CODE_FIRST;
    if (code < CODE_FIRST || code > CODE_LAST) begin
      return 7'd0;
    end
    return diff[6:0];
  endfunction

endpackage

### rtl/glyph_pixel_renderer.sv
// Top level of the glyph pixel renderer: 8x8 font characters to frame buffer pixel writes.
//
//   Channel   Direction  Handshake                   Carries
//   s_axis    in         s_axis_tvalid/tready        kind, font load, cell move, character
//   m_axis    out        m_axis_tvalid/tready        pixel writes, tlast on the 64th pixel
//   cfg       in         cfg_valid/cfg_ready         register index and write data
//
// Load, move and unused-kind items do not block the input. A character holds the input from
// the accepting cycle through one font store read, then one pixel per cycle, each next
// glyph row being read from the single-read font RAM during the row's last pixel. A stall
// on m_axis holds the pixel sequencer. The font store is not cleared by reset; cursor,
// clip window and colors reset at once. Configuration is always ready.
module glyph_pixel_renderer
  import grf_pkg::*;
#(
  parameter int unsigned FONT_BYTES = 768
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: font_index[9:0], font_byte[17:10], cell_column[24:18], cell_row[31:25],
  //        char_code[39:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: pixel_address[20:0], pixel_value[28:21], write_even_field[29],
  //        write_odd_field[30], zero[31]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  grf_cmd_t cmd;
  grf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  grf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_kind_i (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Storage and pixel arithmetic.
  grf_datapath #(
    .FontBytes(FONT_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .cfg_write_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

### rtl/grf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module grf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 768,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/grf_ctrl.sv
// Controller state machine that sequences font loads, moves and character draws.
module grf_ctrl
  import grf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  grf_sts_t   sts_i,
  output grf_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Command decode.
  always_comb begin
    cmd_o            = '0;
    cmd_o.load_font  = accept && (in_kind_i == KIND_LOAD);
    cmd_o.set_cursor = accept && (in_kind_i == KIND_MOVE);
    cmd_o.start_draw = accept && (in_kind_i == KIND_DRAW);
    cmd_o.fetch_row  = (state_q == ST_FETCH);
    cmd_o.emit       = (state_q == ST_EMIT) && sts_i.out_free;
    cmd_o.next_row   = cmd_o.emit && sts_i.col_last && !sts_i.row_last;
    cmd_o.finish     = cmd_o.emit && sts_i.col_last && sts_i.row_last;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start_draw) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/grf_datapath.sv
// Datapath: configuration registers, font store, cursor, pixel counters and output register.
module grf_datapath
  import grf_pkg::*;
#(
  parameter int unsigned FontBytes = 768,
  localparam int unsigned FontAddrW = $clog2(FontBytes)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grf_cmd_t              cmd_i,
  output grf_sts_t              sts_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  cfg_write_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  // Input fields.
  logic [9:0] font_index;
  logic [7:0] font_byte;
  logic [6:0] cell_column;
  logic [6:0] cell_row;
  logic [7:0] char_code;

  assign font_index  = in_data_i[9:0];
  assign font_byte   = in_data_i[17:10];
  assign cell_column = in_data_i[24:18];
  assign cell_row    = in_data_i[31:25];
  assign char_code   = in_data_i[39:32];

  // Configuration registers.
  logic [9:0]  clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
  logic [10:0] line_width_q;
  logic [1:0]  field_mask_q;
  logic [7:0]  fg_color_q, bg_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= 10'd0;
      clip_right_q  <= 10'd1023;
      clip_top_q    <= 10'd0;
      clip_bottom_q <= 10'd1023;
      line_width_q  <= 11'd320;
      field_mask_q  <= 2'd1;
      fg_color_q    <= 8'd0;
      bg_color_q    <= 8'd0;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        REG_CLIP_LEFT:   clip_left_q   <= cfg_data_i[9:0];
        REG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i[9:0];
        REG_CLIP_TOP:    clip_top_q    <= cfg_data_i[9:0];
        REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i[9:0];
        REG_LINE_WIDTH:  line_width_q  <= cfg_data_i[10:0];
        REG_FIELD_MASK:  field_mask_q  <= cfg_data_i[1:0];
        REG_FG_COLOR:    fg_color_q    <= cfg_data_i[7:0];
        REG_BG_COLOR:    bg_color_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Drawing state.
  logic [10:0]       cursor_x_q, cursor_x_d;
  logic [9:0]        cursor_y_q, cursor_y_d;
  logic [2:0]        row_q, row_d;
  logic [2:0]        col_q, col_d;
  logic [6:0]        glyph_q, glyph_d;
  logic [ADDR_W-1:0] row_base_q, row_base_d;
  logic [ADDR_W-1:0] row_product;
  logic [11:0]       cursor_x_sum;

  // One multiply per character gives the first row's base address.
  assign row_product  = ADDR_W'(cursor_y_q) * ADDR_W'(line_width_q);
  assign cursor_x_sum = {1'b0, cursor_x_q} + 12'd8;

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    row_d      = row_q;
    col_d      = col_q;
    glyph_d    = glyph_q;
    row_base_d = row_base_q;
    if (cmd_i.set_cursor) begin
      cursor_x_d = {1'b0, cell_column, 3'b000};
      cursor_y_d = {cell_row, 3'b000};
    end
    if (cmd_i.start_draw) begin
      row_d      = 3'd0;
      col_d      = 3'd0;
      glyph_d    = glyph_of(char_code);
      row_base_d = row_product;
    end
    if (cmd_i.emit) begin
      col_d = col_q + 3'd1;
    end
    if (cmd_i.next_row) begin
      row_d      = row_q + 3'd1;
      row_base_d = row_base_q + ADDR_W'(line_width_q);
    end
    if (cmd_i.finish) begin
      cursor_x_d = cursor_x_sum[11] ? CURSOR_X_MAX : cursor_x_sum[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= 11'd0;
      cursor_y_q <= 10'd0;
      row_q      <= 3'd0;
      col_q      <= 3'd0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q    <= glyph_d;
    row_base_q <= row_base_d;
  end

  // Font store: loads write it, the draw reads one row ahead of the pixels.
  logic                 font_we;
  logic                 font_re;
  logic [2:0]           read_row;
  logic [FontAddrW-1:0] font_raddr;
  logic [7:0]           row_bits;

  assign font_we    = cmd_i.load_font && (32'(font_index) < FontBytes);
  assign font_re    = cmd_i.fetch_row || cmd_i.next_row;
  assign read_row   = cmd_i.next_row ? (row_q + 3'd1) : row_q;
  assign font_raddr = FontAddrW'({glyph_q, read_row});

  grf_ram #(
    .Width(8),
    .Depth(FontBytes)
  ) u_font_ram (
    .clk_i  (clk_i),
    .we_i   (font_we),
    .waddr_i(FontAddrW'(font_index)),
    .wdata_i(font_byte),
    .re_i   (font_re),
    .raddr_i(font_raddr),
    .rdata_o(row_bits)
  );

  // Pixel position, clip test and address.
  logic [11:0]       pix_x;
  logic [9:0]        pix_y;
  logic              in_clip;
  logic              bit_set;
  logic [ADDR_W-1:0] pix_addr;

  assign pix_x    = {1'b0, cursor_x_q} + {9'd0, col_q};
  assign pix_y    = cursor_y_q + {7'd0, row_q};
  assign in_clip  = (pix_x >= {2'b00, clip_left_q}) && (pix_x <= {2'b00, clip_right_q}) &&
                    (pix_y >= clip_top_q) && (pix_y <= clip_bottom_q);
  assign bit_set  = row_bits[~col_q];
  assign pix_addr = row_base_q + ADDR_W'(pix_x);

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {1'b0,
                     in_clip && field_mask_q[1],
                     in_clip && field_mask_q[0],
                     bit_set ? fg_color_q : bg_color_q,
                     pix_addr};
      out_last_q <= (row_q == 3'd7) && (col_q == 3'd7);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // Status to the controller.
  assign sts_o.col_last = (col_q == 3'd7);
  assign sts_o.row_last = (row_q == 3'd7);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

### rtl/grf_checker.sv
// Port-level assertions of the glyph pixel renderer and their bind to the top level.
module grf_checker
  import grf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [1:0]            s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  // A stalled pixel item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled pixel item changed");

  // Accepting a character blocks the input while it is being drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KIND_DRAW) |=>
      !s_axis_tready_o)
    else $error("input ready right after a character was accepted");

  // When the input is open again, a pixel still waiting must close its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("input ready while a character is unfinished");

  // The padding bit of the pixel item stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[OUT_DATA_W-1])
    else $error("pixel item padding bit set");

endmodule

bind glyph_pixel_renderer grf_checker u_grf_checker (.*);

### test/tb_glyph_pixel_renderer.sv
// Self-checking testbench for the glyph pixel renderer: font loads, cursor moves and character draws.
`timescale 1ns / 1ps

// Tracks the font store, cursor and registers, and predicts the pixel writes of each character.
class glyph_raster;
  localparam int unsigned FONT_DEPTH = 768;
  localparam int unsigned CURSOR_LIMIT = 2047;

  typedef struct packed {
    logic [20:0] addr;
    logic [7:0]  value;
    logic        even;
    logic        odd;
    logic        last;
  } pixel_t;

  logic [7:0]  font_rom [FONT_DEPTH];
  bit          font_known [FONT_DEPTH];
  int unsigned cur_x, cur_y;
  int unsigned clip_l, clip_r, clip_t, clip_b, line_w, fmask, fg, bg;
  pixel_t      expected_pixels [$];
  int unsigned mismatches, items, draws, pixels, reg_writes;
  bit          saturated;

  function new();
    cur_x = 0;
    cur_y = 0;
    clip_l = 0;
    clip_r = 1023;
    clip_t = 0;
    clip_b = 1023;
    line_w = 320;
    fmask = 1;
    fg = 0;
    bg = 0;
    mismatches = 0;
    items = 0;
    draws = 0;
    pixels = 0;
    reg_writes = 0;
    saturated = 0;
    foreach (font_known[i]) font_known[i] = 0;
  endfunction

  // Codes outside the printable range fall back to the first glyph.
  function int unsigned glyph_for(logic [7:0] code);
    if (code < grf_pkg::CODE_FIRST || code > grf_pkg::CODE_LAST) return 0;
    return int'(code - grf_pkg::CODE_FIRST);
  endfunction

  function bit glyph_loaded(int unsigned g);
    for (int r = 0; r < 8; r++) begin
      if (!font_known[g * 8 + r]) return 0;
    end
    return 1;
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] val);
    reg_writes++;
    case (idx)
      grf_pkg::REG_CLIP_LEFT:   clip_l = val[9:0];
      grf_pkg::REG_CLIP_RIGHT:  clip_r = val[9:0];
      grf_pkg::REG_CLIP_TOP:    clip_t = val[9:0];
      grf_pkg::REG_CLIP_BOTTOM: clip_b = val[9:0];
      grf_pkg::REG_LINE_WIDTH:  line_w = val;
      grf_pkg::REG_FIELD_MASK:  fmask = val[1:0];
      grf_pkg::REG_FG_COLOR:    fg = val[7:0];
      grf_pkg::REG_BG_COLOR:    bg = val[7:0];
      default: ;
    endcase
  endfunction

  // Applies one accepted item; a draw queues its 64 pixel writes.
  function void note_item(logic [1:0] kind, logic [39:0] data);
    int unsigned base, x, y;
    logic [7:0]  bits;
    bit          in_clip;
    pixel_t      px;
    items++;
    case (kind)
      grf_pkg::KIND_LOAD: begin
        if (data[9:0] < FONT_DEPTH) begin
          font_rom[data[9:0]] = data[17:10];
          font_known[data[9:0]] = 1;
        end
      end
      grf_pkg::KIND_MOVE: begin
        cur_x = int'(data[24:18]) * 8;
        cur_y = int'(data[31:25]) * 8;
      end
      grf_pkg::KIND_DRAW: begin
        draws++;
        base = glyph_for(data[39:32]) * 8;
        for (int r = 0; r < 8; r++) begin
          bits = font_rom[base + r];
          for (int c = 0; c < 8; c++) begin
            x = cur_x + c;
            y = cur_y + r;
            in_clip = x >= clip_l && x <= clip_r && y >= clip_t && y <= clip_b;
            px.addr = y * line_w + x;
            px.value = bits[7 - c] ? fg[7:0] : bg[7:0];
            px.even = in_clip && fmask[0];
            px.odd = in_clip && fmask[1];
            px.last = (r == 7 && c == 7);
            expected_pixels.push_back(px);
          end
        end
        cur_x = (cur_x + 8 > CURSOR_LIMIT) ? CURSOR_LIMIT : cur_x + 8;
        if (cur_x == CURSOR_LIMIT) saturated = 1;
      end
      default: ;
    endcase
  endfunction

  function void compare(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t ns: pixel %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want_v, got_v);
    end
  endfunction

  // Compares one accepted pixel write with the oldest pending one.
  function void check_pixel(logic [31:0] tdata, logic tlast);
    pixel_t want;
    pixels++;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      $display("%0t ns: pixel write 0x%08h arrived with no character pending", $time, tdata);
      return;
    end
    want = expected_pixels.pop_front();
    compare("address", want.addr, tdata[20:0]);
    compare("value", want.value, tdata[28:21]);
    compare("even-field enable", want.even, tdata[29]);
    compare("odd-field enable", want.odd, tdata[30]);
    compare("padding bit", 32'd0, tdata[31]);
    compare("last flag", want.last, tlast);
  endfunction
endclass

module tb_glyph_pixel_renderer;
  import grf_pkg::*;

  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF       = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam logic [7:0]  GLYPH0_ROWS [8] = '{8'h00, 8'hFF, 8'h81, 8'h7E,
                                              8'hAA, 8'h55, 8'h80, 8'h01};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic [1:0]            s_user = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  m_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit          sender_idling = 1'b1;
  bit          sink_idling = 1'b1;
  int unsigned idle_cycles = 0;
  glyph_raster raster = new();

  glyph_pixel_renderer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  // Output backpressure: random stall bursts while idling is on.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        m_ready = 1'b0;
      end else if (sink_idling && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        m_ready = 1'b0;
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  // Every accepted pixel write is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && m_valid === 1'b1 && m_ready) begin
      raster.check_pixel(m_data, m_last);
    end
  end

  // Ends the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [39:0] noise();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[39:0];
  endfunction

  // Picks a character code; a glyph not loaded yet is only drawn now and then when allowed.
  function automatic logic [7:0] pick_code(input bit allow_new);
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    if (!raster.glyph_loaded(raster.glyph_for(code)) &&
        !(allow_new && $urandom_range(0, 3) == 0)) begin
      code = ($urandom_range(0, 1) != 0) ? CODE_LAST : 8'($urandom_range(128, 255));
    end
    return code;
  endfunction

  // Presents one item after an optional gap and waits until it is taken.
  task automatic send_item(input logic [1:0] kind, input logic [39:0] data);
    int unsigned gap;
    gap = (sender_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid = 1'b1;
    s_user = kind;
    s_data = data;
    do @(posedge clk); while (!s_ready);
    raster.note_item(kind, data);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    raster.write_reg(idx, val);
  endtask

  // Writes the whole register set; only called while the block is idle.
  task automatic apply_setting(input logic [10:0] left, input logic [10:0] right,
                               input logic [10:0] top, input logic [10:0] bottom,
                               input logic [10:0] width, input logic [10:0] mask,
                               input logic [10:0] fg, input logic [10:0] bg);
    set_reg(REG_CLIP_LEFT, left);
    set_reg(REG_CLIP_RIGHT, right);
    set_reg(REG_CLIP_TOP, top);
    set_reg(REG_CLIP_BOTTOM, bottom);
    set_reg(REG_LINE_WIDTH, width);
    set_reg(REG_FIELD_MASK, mask);
    set_reg(REG_FG_COLOR, fg);
    set_reg(REG_BG_COLOR, bg);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops sending, waits for all pixel writes, then lets trailing work finish.
  task automatic settle();
    @(negedge clk);
    s_valid = 1'b0;
    while (raster.expected_pixels.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic load_font(input int unsigned idx, input logic [7:0] bits);
    logic [39:0] d;
    d = noise();
    d[9:0] = idx;
    d[17:10] = bits;
    send_item(KIND_LOAD, d);
  endtask

  task automatic move_to(input int unsigned col, input int unsigned row);
    logic [39:0] d;
    d = noise();
    d[24:18] = col;
    d[31:25] = row;
    send_item(KIND_MOVE, d);
  endtask

  // Draws a character, first loading its glyph if any row is still unknown.
  task automatic draw_char(input logic [7:0] code);
    logic [39:0] d;
    int unsigned g;
    g = raster.glyph_for(code);
    if (!raster.glyph_loaded(g)) begin
      for (int r = 0; r < 8; r++) load_font(g * 8 + r, $urandom_range(0, 255));
    end
    d = noise();
    d[39:32] = code;
    send_item(KIND_DRAW, d);
  endtask

  // Picks a cell next to one of the clip edges so characters straddle them.
  function automatic int unsigned cell_near(input int unsigned edge_lo, input int unsigned edge_hi);
    int c;
    c = int'(($urandom_range(0, 1) != 0 ? edge_lo : edge_hi) / 8) + int'($urandom_range(0, 2)) - 1;
    if (c < 0) c = 0;
    if (c > 127) c = 127;
    return c;
  endfunction

  // Mixed traffic: mostly moves and draws, some stray loads and unused kinds.
  task automatic random_phase(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 10 == 0) begin
        sender_idling = $urandom_range(0, 2) != 0;
        sink_idling = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 11) == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        load_font($urandom_range(0, 1023), $urandom_range(0, 255));
      end else if (pick < 15) begin
        send_item(KIND_UNUSED, noise());
      end else if (pick < 40) begin
        if ($urandom_range(0, 1) != 0) begin
          move_to(cell_near(raster.clip_l, raster.clip_r), cell_near(raster.clip_t, raster.clip_b));
        end else begin
          move_to($urandom_range(0, 127), $urandom_range(0, 127));
        end
      end else begin
        draw_char(pick_code(1'b1));
      end
    end
  endtask

  initial begin
    int unsigned lo, hi, vlo, vhi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: full window, extreme colors, fallback glyph and the last glyph.
    apply_setting(11'd0, 11'd1023, 11'd0, 11'd1023, 11'd1024, 11'd3, 11'd255, 11'd0);
    for (int r = 0; r < 8; r++) load_font(r, GLYPH0_ROWS[r]);
    for (int r = 0; r < 8; r++) begin
      load_font(int'(CODE_LAST - CODE_FIRST) * 8 + r, $urandom_range(0, 255));
    end
    load_font(1023, 8'hFF);
    send_item(KIND_UNUSED, '1);
    draw_char(8'd0);
    move_to(127, 127);
    draw_char(CODE_LAST);
    draw_char(8'd255);
    move_to(0, 0);
    draw_char(CODE_FIRST - 8'd1);
    draw_char(CODE_LAST + 8'd1);
    draw_char(CODE_FIRST);
    settle();

    // Narrow random window, even field only, with a forced drain halfway.
    lo = $urandom_range(0, 1023);
    hi = (lo + $urandom_range(0, 200) > 1023) ? 1023 : lo + $urandom_range(0, 200);
    vlo = $urandom_range(0, 1023);
    vhi = (vlo + $urandom_range(0, 200) > 1023) ? 1023 : vlo + $urandom_range(0, 200);
    apply_setting(lo, hi, vlo, vhi, $urandom_range(1, 1024), 11'd1,
                  $urandom_range(0, 255), $urandom_range(0, 255));
    random_phase(4);
    settle();
    random_phase(4);
    settle();

    // Empty clip window and a zero line width.
    lo = $urandom_range(1, 1023);
    apply_setting(lo, $urandom_range(0, lo - 1), $urandom_range(0, 1023), $urandom_range(0, 1023),
                  11'd0, 11'd2, 11'd0, 11'd255);
    random_phase(4);
    settle();

    // Widest line, all fields masked off.
    apply_setting(11'd0, 11'd1023, 11'd0, 11'd1023, 11'd2047, 11'd0,
                  $urandom_range(0, 255), $urandom_range(0, 255));
    random_phase(4);
    settle();

    // Everything random, unused register bits included.
    apply_setting($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
    random_phase(4);
    settle();

    // Long line of characters from the rightmost cell until the cursor saturates.
    sender_idling = 1'b0;
    sink_idling = 1'b0;
    apply_setting(11'd0, 11'd1023, 11'd0, 11'd1023, $urandom_range(1, 1024), 11'd3,
                  $urandom_range(0, 255), $urandom_range(0, 255));
    move_to(127, $urandom_range(0, 127));
    repeat (130) draw_char(pick_code(1'b0));

    @(negedge clk);
    s_valid = 1'b0;
    while (raster.expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items, %0d characters, %0d pixel writes and %0d register writes.",
             raster.items, raster.draws, raster.pixels, raster.reg_writes);
    $display("Clip, field mask and line width extremes were used; cursor x saturation %s.",
             raster.saturated ? "was reached" : "was not reached");
    if (raster.mismatches == 0 && raster.expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/grf_pkg.sv
rtl/grf_ram.sv
rtl/grf_ctrl.sv
rtl/grf_datapath.sv
rtl/glyph_pixel_renderer.sv
rtl/grf_checker.sv
test/tb_glyph_pixel_renderer.sv
